@@ src/usd_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none
package usd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned LEN_W  = 3;

  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'b0011_1111;
  localparam logic [BYTE_W-1:0] CONT_LEAD  = 8'b1000_0000;
  localparam logic [BYTE_W-1:0] ONE_MASK   = 8'b0111_1111;
  localparam logic [BYTE_W-1:0] TWO_MASK   = 8'b0001_1111;
  localparam logic [BYTE_W-1:0] TWO_LEAD   = 8'b1100_0000;
  localparam logic [BYTE_W-1:0] THREE_MASK = 8'b0000_1111;
  localparam logic [BYTE_W-1:0] THREE_LEAD = 8'b1110_0000;
  localparam logic [BYTE_W-1:0] FOUR_MASK  = 8'b0000_0111;
  localparam logic [BYTE_W-1:0] FOUR_LEAD  = 8'b1111_0000;

  localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

  // Role of one byte, settled by the front end.
  typedef enum logic [1:0] {
    KIND_ASCII,
    KIND_LEAD,
    KIND_CONT,
    KIND_BAD
  } byte_kind_t;

  // Classified byte as it travels through the queue.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    byte_kind_t        kind;
    logic              last;
    logic [LEN_W-1:0]  len;
  } usd_item_t;

endpackage
`default_nettype wire

@@ src/usd_front.sv @@
// Front end: takes bytes and classifies them against the open sequence.
`default_nettype none
module usd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid_i,
  input  wire logic [7:0]         in_byte_i,
  input  wire logic               q_full_i,
  output logic                    in_ready_o,
  output logic                    push_o,
  output usd_pkg::usd_item_t      item_o
);
  import usd_pkg::*;

  logic [1:0]       rem_r, rem_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;

  always_comb begin
    item_o.data = in_byte_i;
    item_o.kind = KIND_BAD;
    item_o.last = 1'b1;
    item_o.len  = LEN_ONE;
    rem_nxt     = rem_r;
    len_nxt     = len_r;
    if (rem_r != 2'd0) begin
      // any byte inside an open sequence counts as a continuation
      item_o.kind = KIND_CONT;
      item_o.last = (rem_r == 2'd1);
      item_o.len  = len_r;
      rem_nxt     = rem_r - 2'd1;
    end else begin
      priority if ((in_byte_i & ~ONE_MASK) == 8'h00) begin
        item_o.kind = KIND_ASCII;
      end else if ((in_byte_i & ~TWO_MASK) == TWO_LEAD) begin
        item_o.kind = KIND_LEAD;
        item_o.last = 1'b0;
        item_o.len  = LEN_TWO;
        rem_nxt     = 2'd1;
        len_nxt     = LEN_TWO;
      end else if ((in_byte_i & ~THREE_MASK) == THREE_LEAD) begin
        item_o.kind = KIND_LEAD;
        item_o.last = 1'b0;
        item_o.len  = LEN_THREE;
        rem_nxt     = 2'd2;
        len_nxt     = LEN_THREE;
      end else if ((in_byte_i & ~FOUR_MASK) == FOUR_LEAD) begin
        item_o.kind = KIND_LEAD;
        item_o.last = 1'b0;
        item_o.len  = LEN_FOUR;
        rem_nxt     = 2'd3;
        len_nxt     = LEN_FOUR;
      end else begin
        // stray continuation or invalid lead: one flagged byte
        item_o.kind = KIND_BAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
      len_r <= LEN_ONE;
    end else if (accept) begin
      rem_r <= rem_nxt;
      len_r <= len_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/usd_fifo.sv @@
// Short queue of classified bytes between front and back end.
`default_nettype none
module usd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_i,
  input  usd_pkg::usd_item_t      item_i,
  input  wire logic               pop_i,
  output logic                    full_o,
  output logic                    empty_o,
  output usd_pkg::usd_item_t      item_o
);
  import usd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  usd_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full_o  = (cnt_r == CNT_W'(DEPTH));
  assign empty_o = (cnt_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= item_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ src/usd_back.sv @@
// Back end: assembles code points and holds the output register.
`default_nettype none
module usd_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_empty_i,
  input  usd_pkg::usd_item_t          item_i,
  output logic                        pop_o,
  input  wire logic                   out_ready_i,
  output logic                        out_valid_o,
  output logic [usd_pkg::CP_W-1:0]    code_point_o,
  output logic [usd_pkg::LEN_W-1:0]   seq_length_o,
  output logic                        malformed_o
);
  import usd_pkg::*;

  logic [CP_W-1:0]  acc_r, acc_nxt;
  logic             out_valid_r;
  logic [CP_W-1:0]  cp_r, cp_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             mal_r, mal_nxt;
  logic             emit, out_free;

  assign out_free = !out_valid_r || out_ready_i;

  always_comb begin
    acc_nxt = acc_r;
    cp_nxt  = 21'(item_i.data & ONE_MASK);
    len_nxt = LEN_ONE;
    mal_nxt = 1'b0;
    emit    = 1'b0;
    unique case (item_i.kind)
      KIND_ASCII: begin
        emit = 1'b1;
      end
      KIND_BAD: begin
        emit    = 1'b1;
        mal_nxt = 1'b1;
      end
      KIND_LEAD: begin
        unique case (item_i.len)
          LEN_TWO:   acc_nxt = 21'(item_i.data & TWO_MASK);
          LEN_THREE: acc_nxt = 21'(item_i.data & THREE_MASK);
          default:   acc_nxt = 21'(item_i.data & FOUR_MASK);
        endcase
      end
      KIND_CONT: begin
        acc_nxt = {acc_r[CP_W-7:0], item_i.data[5:0]};
        cp_nxt  = acc_nxt;
        len_nxt = item_i.len;
        emit    = item_i.last;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // hold a byte that would emit while the output register is stalled
  assign pop_o = !q_empty_i && (!emit || out_free);

  always_ff @(posedge clk) begin
    if (pop_o) begin
      acc_r <= acc_nxt;
    end
    if (pop_o && emit) begin
      cp_r  <= cp_nxt;
      len_r <= len_nxt;
      mal_r <= mal_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_o && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_r;
  assign code_point_o = cp_r;
  assign seq_length_o = len_r;
  assign malformed_o  = mal_r;

endmodule
`default_nettype wire

@@ src/utf8_stream_decoder_core.sv @@
// Top level of the UTF-8 stream decoder.
// Decodes a UTF-8 byte stream at one byte per cycle while the queue has room. The classifier
// is combinational and writes each accepted byte into the queue at the accepting edge.
// The back end pops the byte at the queue head and loads the output register when that byte
// completes a code point; such a byte waits in the queue while the output is stalled.
// Malformed leads (11111xxx) and stray continuation bytes come out as one-byte items masked
// to 7 bits with tuser set; continuation prefixes are not checked. The QUEUE_DEPTH-entry
// queue absorbs output stalls so input keeps flowing while a result waits, until it is full.
`default_nettype none
module utf8_stream_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_in
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [20:0] code_point, [23:21] seq_length
  output logic [0:0]       out_tuser   // [0] malformed
);
  import usd_pkg::*;

  usd_item_t        fr_item, q_item;
  logic             push, pop, q_full, q_empty;
  logic [CP_W-1:0]  code_point;
  logic [LEN_W-1:0] seq_length;
  logic             malformed;

  usd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_tvalid),
    .in_byte_i  (in_tdata),
    .q_full_i   (q_full),
    .in_ready_o (in_tready),
    .push_o     (push),
    .item_o     (fr_item)
  );

  usd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .item_i  (fr_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  usd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty_i    (q_empty),
    .item_i       (q_item),
    .pop_o        (pop),
    .out_ready_i  (out_tready),
    .out_valid_o  (out_tvalid),
    .code_point_o (code_point),
    .seq_length_o (seq_length),
    .malformed_o  (malformed)
  );

  assign out_tdata = {seq_length, code_point};
  assign out_tuser = malformed;

endmodule
`default_nettype wire

@@ src/usd_checker.sv @@
// Port-level checker for the UTF-8 stream decoder, bound to the top level.
`default_nettype none
module usd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  // hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:21] == 3'd1) || (out_tdata[23:21] == 3'd2) ||
                   (out_tdata[23:21] == 3'd3) || (out_tdata[23:21] == 3'd4))
    else $error("sequence length out of range");

  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[23:21] == 3'd1)
    else $error("flagged item longer than one byte");

  a_one_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[23:21] == 3'd1 |-> out_tdata[20:7] == 14'd0)
    else $error("one-byte code point above 7 bits");

  a_two_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[23:21] == 3'd2 |-> out_tdata[20:11] == 10'd0 && !out_tuser[0])
    else $error("two-byte code point above 11 bits");

endmodule

bind utf8_stream_decoder_core usd_checker u_usd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
